// ===== rtl/flocking_steering_kernel_defines.svh =====
// Assertion macros shared by the flocking steering kernel RTL.
// Included by the top level; expects clk and rst_n in scope.
`ifndef FLOCKING_STEERING_KERNEL_DEFINES_SVH
`define FLOCKING_STEERING_KERNEL_DEFINES_SVH

// Condition and consequence in the same cycle.
`define FSK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define FSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fsk_pkg.sv =====
// Shared types and constants for the flocking steering kernel.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package fsk_pkg;

  localparam int unsigned MAX_NEIGHBOURS_DEF = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIGHT_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_DIST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_WEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COH_WEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALI_WEIGHT  = 3'd4;

  localparam logic [15:0] SIGHT_RANGE_RST = 16'd1600;
  localparam logic [15:0] SEP_DIST_RST    = 16'd800;
  localparam logic [11:0] WEIGHT_RST      = 12'd256;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned WEIGHT_W = 12;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned STEER_W  = 18;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned MAC_W    = 31;

  typedef enum logic [1:0] {
    VSEL_SEP = 2'd0,
    VSEL_COH = 2'd1,
    VSEL_ALI = 2'd2
  } vsel_t;

  typedef struct packed {
    logic  cap;
    logic  meas;
    logic  sqr;
    logic  acc;
    logic  uv_start;
    logic  mac;
    logic  out_load;
    vsel_t vsel;
  } fsk_cmd_t;

  typedef struct packed {
    logic is_self;
    logic last;
    logic uv_done;
    logic out_busy;
  } fsk_sts_t;

endpackage

// ===== rtl/fsk_unitvec.sv =====
// Iterative unit-vector unit: normalize shift, bit-serial square root, two
// restoring dividers. Depends on fsk_pkg.
`timescale 1ns / 1ps
module fsk_unitvec #(
  parameter int unsigned UW = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [UW-1:0]           vx,
  input  logic signed [UW-1:0]           vy,
  output logic                           done,
  output logic                           busy,
  output logic signed [fsk_pkg::UNIT_W-1:0] ux,
  output logic signed [fsk_pkg::UNIT_W-1:0] uy
);

  typedef enum logic [5:0] {
    UV_IDLE  = 6'b000001,
    UV_NORM  = 6'b000010,
    UV_SQ    = 6'b000100,
    UV_ROOT  = 6'b001000,
    UV_DINIT = 6'b010000,
    UV_DIV   = 6'b100000
  } uv_state_t;

  localparam logic [15:0] Q_ONE = 16'd16384;

  uv_state_t st_r, st_nxt;
  logic [UW-1:0] ax_r, ay_r;
  logic          negx_r, negy_r;
  logic [59:0]   rad_r;
  logic [29:0]   root_r;
  logic [31:0]   rem_r;
  logic [4:0]    it_r;
  logic [29:0]   remx_r, remy_r;
  logic [15:0]   nx_r, ny_r, qx_r, qy_r;
  logic          done_r;

  logic [UW-1:0] mx;
  logic [33:0]   t_rem, trial;
  logic [30:0]   sum_sq;
  logic [43:0]   numx, numy;
  logic [30:0]   tx, ty;
  logic [15:0]   qxc, qyc;

  always_comb begin
    mx     = (ax_r > ay_r) ? ax_r : ay_r;
    t_rem  = {rem_r, rad_r[59:58]};
    trial  = {2'b00, root_r, 2'b01};
    sum_sq = 31'(ax_r[14:0] * ax_r[14:0]) + 31'(ay_r[14:0] * ay_r[14:0]);
    numx   = {1'b0, ax_r[14:0], 28'd0} + {15'd0, root_r[29:1]};
    numy   = {1'b0, ay_r[14:0], 28'd0} + {15'd0, root_r[29:1]};
    tx     = {remx_r, nx_r[15]};
    ty     = {remy_r, ny_r[15]};
    qxc    = (qx_r > Q_ONE) ? Q_ONE : qx_r;
    qyc    = (qy_r > Q_ONE) ? Q_ONE : qy_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      UV_IDLE:  if (start && (vx != '0 || vy != '0)) st_nxt = UV_NORM;
      UV_NORM:  if (mx < UW'(32768) && mx[14]) st_nxt = UV_SQ;
      UV_SQ:    st_nxt = UV_ROOT;
      UV_ROOT:  if (it_r == '0) st_nxt = UV_DINIT;
      UV_DINIT: st_nxt = UV_DIV;
      UV_DIV:   if (it_r == '0) st_nxt = UV_IDLE;
      default:  st_nxt = UV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= UV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == UV_IDLE && start && vx == '0 && vy == '0) ||
                (st_r == UV_DIV && it_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      UV_IDLE: begin
        if (start) begin
          ax_r   <= vx[UW-1] ? UW'(-vx) : UW'(vx);
          ay_r   <= vy[UW-1] ? UW'(-vy) : UW'(vy);
          negx_r <= vx[UW-1];
          negy_r <= vy[UW-1];
          // A zero vector gives a zero result without a pass.
          if (vx == '0 && vy == '0) begin
            qx_r <= '0;
            qy_r <= '0;
          end
        end
      end
      UV_NORM: begin
        if (mx >= UW'(32768)) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (!mx[14]) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      UV_SQ: begin
        rad_r  <= {1'b0, sum_sq, 28'd0};
        root_r <= '0;
        rem_r  <= '0;
        it_r   <= 5'd29;
      end
      UV_ROOT: begin
        if (t_rem >= trial) begin
          rem_r  <= 32'(t_rem - trial);
          root_r <= {root_r[28:0], 1'b1};
        end else begin
          rem_r  <= t_rem[31:0];
          root_r <= {root_r[28:0], 1'b0};
        end
        rad_r <= rad_r << 2;
        it_r  <= it_r - 5'd1;
      end
      UV_DINIT: begin
        remx_r <= {2'b00, numx[43:16]};
        remy_r <= {2'b00, numy[43:16]};
        nx_r   <= numx[15:0];
        ny_r   <= numy[15:0];
        qx_r   <= '0;
        qy_r   <= '0;
        it_r   <= 5'd15;
      end
      UV_DIV: begin
        if (tx >= {1'b0, root_r}) begin
          remx_r <= 30'(tx - {1'b0, root_r});
          qx_r   <= {qx_r[14:0], 1'b1};
        end else begin
          remx_r <= tx[29:0];
          qx_r   <= {qx_r[14:0], 1'b0};
        end
        if (ty >= {1'b0, root_r}) begin
          remy_r <= 30'(ty - {1'b0, root_r});
          qy_r   <= {qy_r[14:0], 1'b1};
        end else begin
          remy_r <= ty[29:0];
          qy_r   <= {qy_r[14:0], 1'b0};
        end
        nx_r <= nx_r << 1;
        ny_r <= ny_r << 1;
        it_r <= it_r - 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Sign and clamp are applied on the quotient registers directly; they hold
  // their value from the cycle done rises until the next start.
  always_comb begin
    ux = negx_r ? -qxc : qxc;
    uy = negy_r ? -qyc : qyc;
  end

  assign done = done_r;
  assign busy = (st_r != UV_IDLE);

endmodule

// ===== rtl/fsk_datapath.sv =====
// Datapath of the flocking steering kernel: config registers, member
// accumulators, unit-vector unit, weighted sum and output register. Uses fsk_pkg.
`timescale 1ns / 1ps
module fsk_datapath #(
  parameter int unsigned MAX_NEIGHBOURS = fsk_pkg::MAX_NEIGHBOURS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fsk_pkg::fsk_cmd_t                    cmd,
  output fsk_pkg::fsk_sts_t                    sts,
  input  logic                                 cfg_we,
  input  logic [fsk_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [fsk_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_self,
  input  logic signed [fsk_pkg::POS_W-1:0]     in_px,
  input  logic signed [fsk_pkg::POS_W-1:0]     in_py,
  input  logic signed [fsk_pkg::DIR_W-1:0]     in_dx,
  input  logic signed [fsk_pkg::DIR_W-1:0]     in_dy,
  input  logic                                 in_last,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [fsk_pkg::STEER_W-1:0]   steer_x,
  output logic signed [fsk_pkg::STEER_W-1:0]   steer_y,
  output logic [fsk_pkg::COUNT_W-1:0]          count,
  output logic                                 uv_busy
);

  localparam int unsigned CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned OW = 17 + CW;
  localparam int unsigned PW = 16 + CW;
  localparam int unsigned HW = 16 + CW;
  localparam int unsigned UW = 18 + CW;
  localparam int unsigned SW = fsk_pkg::STEER_W;

  logic [15:0] sight_r, sepd_r;
  logic [fsk_pkg::WEIGHT_W-1:0] wsep_r, wcoh_r, wali_r;

  logic        self_in_r, last_in_r;
  logic signed [15:0] px_r, py_r, hx_r, hy_r;
  logic signed [15:0] selfx_r, selfy_r;
  logic signed [16:0] dx_r, dy_r;
  logic [31:0] sqx_r, sqy_r, sr2_r, sd2_r;
  logic signed [OW-1:0] osx_r, osy_r;
  logic signed [PW-1:0] psx_r, psy_r;
  logic signed [HW-1:0] hsx_r, hsy_r;
  logic [CW-1:0] cnt_r;
  logic signed [fsk_pkg::MAC_W-1:0] accx_r, accy_r;
  logic        outv_r;
  logic signed [SW-1:0] stx_r, sty_r;
  logic [fsk_pkg::COUNT_W-1:0] cnto_r;

  logic [32:0] d2;
  logic        take, near;
  logic signed [UW-1:0] vx, vy, cohx, cohy;
  logic signed [fsk_pkg::UNIT_W-1:0] ux, uy;
  logic        uv_done;
  logic [fsk_pkg::WEIGHT_W-1:0] w;
  logic signed [28:0] prodx, prody;
  logic signed [fsk_pkg::MAC_W-1:0] rx_full, ry_full;
  logic signed [fsk_pkg::MAC_W-9:0] rx, ry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sight_r <= fsk_pkg::SIGHT_RANGE_RST;
      sepd_r  <= fsk_pkg::SEP_DIST_RST;
      wsep_r  <= fsk_pkg::WEIGHT_RST;
      wcoh_r  <= fsk_pkg::WEIGHT_RST;
      wali_r  <= fsk_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fsk_pkg::REG_SIGHT_RANGE: sight_r <= cfg_wdata;
        fsk_pkg::REG_SEP_DIST:    sepd_r  <= cfg_wdata;
        fsk_pkg::REG_SEP_WEIGHT:  wsep_r  <= cfg_wdata[fsk_pkg::WEIGHT_W-1:0];
        fsk_pkg::REG_COH_WEIGHT:  wcoh_r  <= cfg_wdata[fsk_pkg::WEIGHT_W-1:0];
        fsk_pkg::REG_ALI_WEIGHT:  wali_r  <= cfg_wdata[fsk_pkg::WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    d2    = {1'b0, sqx_r} + {1'b0, sqy_r};
    take  = (d2 != '0) && (d2 <= {1'b0, sr2_r}) && (cnt_r < CW'(MAX_NEIGHBOURS));
    near  = d2 < {1'b0, sd2_r};
    cohx  = UW'(selfx_r * $signed({1'b0, cnt_r})) - UW'(psx_r);
    cohy  = UW'(selfy_r * $signed({1'b0, cnt_r})) - UW'(psy_r);
    case (cmd.vsel)
      fsk_pkg::VSEL_SEP: begin
        vx = UW'(osx_r);
        vy = UW'(osy_r);
        w  = wsep_r;
      end
      fsk_pkg::VSEL_COH: begin
        vx = (psx_r == '0 && psy_r == '0) ? '0 : cohx;
        vy = (psx_r == '0 && psy_r == '0) ? '0 : cohy;
        w  = wcoh_r;
      end
      default: begin
        vx = UW'(hsx_r);
        vy = UW'(hsy_r);
        w  = wali_r;
      end
    endcase
    prodx   = $signed({1'b0, w}) * ux;
    prody   = $signed({1'b0, w}) * uy;
    rx_full = (accx_r + fsk_pkg::MAC_W'(128)) >>> 8;
    ry_full = (accy_r + fsk_pkg::MAC_W'(128)) >>> 8;
    rx      = rx_full[fsk_pkg::MAC_W-9:0];
    ry      = ry_full[fsk_pkg::MAC_W-9:0];
  end

  fsk_unitvec #(.UW(UW)) u_unitvec (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.uv_start),
    .vx    (vx),
    .vy    (vy),
    .done  (uv_done),
    .busy  (uv_busy),
    .ux    (ux),
    .uy    (uy)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      self_in_r <= in_self;
      last_in_r <= in_last;
      px_r <= in_px;
      py_r <= in_py;
      hx_r <= in_dx;
      hy_r <= in_dy;
    end
    if (cmd.meas) begin
      dx_r   <= 17'(px_r) - 17'(selfx_r);
      dy_r   <= 17'(py_r) - 17'(selfy_r);
      accx_r <= '0;
      accy_r <= '0;
    end
    if (cmd.sqr) begin
      sqx_r <= 32'(dx_r * dx_r);
      sqy_r <= 32'(dy_r * dy_r);
      sr2_r <= sight_r * sight_r;
      sd2_r <= sepd_r * sepd_r;
    end
    if (cmd.mac) begin
      accx_r <= accx_r + fsk_pkg::MAC_W'(prodx);
      accy_r <= accy_r + fsk_pkg::MAC_W'(prody);
    end
    if (cmd.out_load) begin
      stx_r  <= (rx > (SW+5)'(131071)) ? SW'(131071) :
                (rx < -(SW+5)'(131072)) ? -SW'(131072) : SW'(rx);
      sty_r  <= (ry > (SW+5)'(131071)) ? SW'(131071) :
                (ry < -(SW+5)'(131072)) ? -SW'(131072) : SW'(ry);
      cnto_r <= fsk_pkg::COUNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selfx_r <= '0;
      selfy_r <= '0;
      osx_r <= '0; osy_r <= '0;
      psx_r <= '0; psy_r <= '0;
      hsx_r <= '0; hsy_r <= '0;
      cnt_r <= '0;
      outv_r <= 1'b0;
    end else begin
      if (cmd.meas && self_in_r) begin
        selfx_r <= px_r;
        selfy_r <= py_r;
      end
      if ((cmd.meas && self_in_r) || cmd.out_load) begin
        osx_r <= '0; osy_r <= '0;
        psx_r <= '0; psy_r <= '0;
        hsx_r <= '0; hsy_r <= '0;
        cnt_r <= '0;
      end else if (cmd.acc && take) begin
        if (near) begin
          osx_r <= osx_r + OW'(dx_r);
          osy_r <= osy_r + OW'(dy_r);
        end
        psx_r <= psx_r + PW'(px_r);
        psy_r <= psy_r + PW'(py_r);
        hsx_r <= hsx_r + HW'(hx_r);
        hsy_r <= hsy_r + HW'(hy_r);
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.out_load) outv_r <= 1'b1;
      else if (out_ready) outv_r <= 1'b0;
    end
  end

  always_comb begin
    sts.is_self  = self_in_r;
    sts.last     = last_in_r;
    sts.uv_done  = uv_done;
    sts.out_busy = outv_r && !out_ready;
  end

  assign out_valid = outv_r;
  assign steer_x   = stx_r;
  assign steer_y   = sty_r;
  assign count     = cnto_r;

endmodule

// ===== rtl/fsk_ctrl.sv =====
// Controller state machine of the flocking steering kernel.
// Drives datapath commands from status; uses fsk_pkg.
`timescale 1ns / 1ps
module fsk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsk_pkg::fsk_sts_t sts,
  output fsk_pkg::fsk_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MEAS   = 8'b00000010,
    S_SQR    = 8'b00000100,
    S_ACC    = 8'b00001000,
    S_UVGO   = 8'b00010000,
    S_UVWAIT = 8'b00100000,
    S_MAC    = 8'b01000000,
    S_FIN    = 8'b10000000
  } ctrl_state_t;

  ctrl_state_t st_r, st_nxt;
  fsk_pkg::vsel_t vsel_r, vsel_nxt;

  always_comb begin
    st_nxt       = st_r;
    vsel_nxt     = vsel_r;
    cmd          = '0;
    cmd.vsel     = vsel_r;
    in_ready     = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          st_nxt  = S_MEAS;
        end
      end
      S_MEAS: begin
        cmd.meas = 1'b1;
        if (!sts.is_self) st_nxt = S_SQR;
        else if (sts.last) begin
          st_nxt   = S_UVGO;
          vsel_nxt = fsk_pkg::VSEL_SEP;
        end else st_nxt = S_IDLE;
      end
      S_SQR: begin
        cmd.sqr = 1'b1;
        st_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) begin
          st_nxt   = S_UVGO;
          vsel_nxt = fsk_pkg::VSEL_SEP;
        end else st_nxt = S_IDLE;
      end
      S_UVGO: begin
        cmd.uv_start = 1'b1;
        st_nxt       = S_UVWAIT;
      end
      S_UVWAIT: begin
        if (sts.uv_done) st_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        case (vsel_r)
          fsk_pkg::VSEL_SEP: begin
            vsel_nxt = fsk_pkg::VSEL_COH;
            st_nxt   = S_UVGO;
          end
          fsk_pkg::VSEL_COH: begin
            vsel_nxt = fsk_pkg::VSEL_ALI;
            st_nxt   = S_UVGO;
          end
          default: st_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      vsel_r <= fsk_pkg::VSEL_SEP;
    end else begin
      st_r   <= st_nxt;
      vsel_r <= vsel_nxt;
    end
  end

endmodule

// ===== rtl/flocking_steering_kernel.sv =====
// Top level of the flocking steering kernel: stream ports, config port,
// controller and datapath. Depends on fsk_pkg, fsk_ctrl, fsk_datapath.
`timescale 1ns / 1ps
`include "flocking_steering_kernel_defines.svh"

// The kernel takes one beat per boid item and works on one item at a time.
// A beat with is_self set loads the own position and clears the sums. A
// member beat is measured against the stored self position by capture,
// subtract, square, and compare and accumulate steps, and the next beat is
// taken only after the last of them. The beat that carries last_member
// then runs three unit-vector passes through one shared iterative unit. A
// pass normalizes by shifting (no vector needs more than 14 shifts at the
// default width), then squares, takes the bit-serial square root, sets up
// the dividers and divides, framed by the controller's start, wait and
// multiply-accumulate states; a zero vector skips the unit's steps.
// The result beat is held in an output register, so new items are taken
// while it waits for out_tready; a second result waits until the first one
// has been taken.
module flocking_steering_kernel #(
  parameter int unsigned MAX_NEIGHBOURS = fsk_pkg::MAX_NEIGHBOURS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // pos_x[15:0], pos_y[31:16], dir_x[47:32], dir_y[63:48]
  input  logic        in_tuser,  // is_self
  input  logic        in_tlast,  // last_member
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // steer_x[17:0], steer_y[35:18], neighbour_count[42:36]
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [fsk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsk_pkg::CFG_DATA_W-1:0] cfg_data
);

  fsk_pkg::fsk_cmd_t cmd;
  fsk_pkg::fsk_sts_t sts;
  logic signed [fsk_pkg::STEER_W-1:0] steer_x, steer_y;
  logic [fsk_pkg::COUNT_W-1:0] neighbour_count;
  logic uv_busy;

  // The addressed register is written whenever a beat arrives on the config channel; indices 5 to 7 write nothing.
  assign cfg_ready = 1'b1;

  fsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsk_datapath #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_self   (in_tuser),
    .in_px     (in_tdata[15:0]),
    .in_py     (in_tdata[31:16]),
    .in_dx     (in_tdata[47:32]),
    .in_dy     (in_tdata[63:48]),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .steer_x   (steer_x),
    .steer_y   (steer_y),
    .count     (neighbour_count),
    .uv_busy   (uv_busy)
  );

  assign out_tdata = {5'd0, neighbour_count, steer_y, steer_x};

  // The input side never opens while the unit-vector unit is working.
  `FSK_ASSERT_SAME(a_ready_not_busy, in_tready, !uv_busy, "input ready during vector pass")
  // Loading a result always presents a beat in the next cycle.
  `FSK_ASSERT_NEXT(a_load_valid, cmd.out_load, out_tvalid, "result load lost")
  // A result never overwrites a beat that has not been taken.
  `FSK_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(out_tvalid && !out_tready),
                   "result overwrote pending beat")

endmodule
